// ===== sv/assert_macros.svh =====
// Assertion macros used by the trace ring back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/ttr_pkg.sv =====
// Types and constants for the timestamped trace ring
package ttr_pkg;

  localparam int DEFAULT_RING_DEPTH = 16384;
  localparam int CMD_Q_DEPTH        = 4;
  localparam int RES_Q_DEPTH        = 2;
  localparam int TICK_W             = 64;
  localparam int TICK_DIGITS        = 20;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic              is_read;
    logic              is_eol;
    logic [7:0]        char_byte;
    logic [TICK_W-1:0] tick_now;
    logic [14:0]       window_size;
    logic [13:0]       read_index;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        in_range;
    logic [14:0] copy_length;
    logic        status;
  } result_t;

endpackage

// ===== sv/ttr_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end
module ttr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic           kind,
  input  logic [7:0]     char_byte,
  input  logic [63:0]    tick_now,
  input  logic [14:0]    window_size,
  input  logic [13:0]    read_index,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output ttr_pkg::cmd_t  cmd
);
  import ttr_pkg::*;

  localparam int QPW = $clog2(CMD_Q_DEPTH);

  cmd_t           q [CMD_Q_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QPW:0]   count;
  cmd_t           incoming;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    incoming.is_read     = kind;
    incoming.is_eol      = (char_byte == CH_LF) || (char_byte == CH_CR);
    incoming.char_byte   = char_byte;
    incoming.tick_now    = tick_now;
    incoming.window_size = window_size;
    incoming.read_index  = read_index;
  end

  assign full      = (count == (QPW+1)'(CMD_Q_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPW+1)'(do_push) - (QPW+1)'(do_pop);
    end
  end

endmodule

// ===== sv/ttr_back.sv =====
// Back end: ring writes, line prefix generation and snapshot reads
`include "assert_macros.svh"

module ttr_back #(
  parameter int RING_DEPTH = ttr_pkg::DEFAULT_RING_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  ttr_pkg::cmd_t     cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output ttr_pkg::result_t  res
);
  import ttr_pkg::*;

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int FW  = $clog2(RING_DEPTH + 1);
  localparam int CW  = (FW > 15) ? FW : 15;
  localparam int SW  = ((PW > 15) ? PW : 15) + 2;
  localparam int DW  = $clog2(TICK_DIGITS);
  localparam int BW  = $clog2(TICK_W);

  typedef enum logic [3:0] {
    S_IDLE, S_CONV, S_OPEN, S_DIGIT, S_CLOSE, S_SPACE, S_CHAR,
    S_RD_CALC, S_RD_MEM, S_RD_OUT
  } state_t;

  state_t            state;
  cmd_t              cur;
  logic [PW-1:0]     head_ptr;
  logic [FW-1:0]     fill_count;
  logic              at_line_start;
  logic [TICK_W-1:0] tick_sh;
  logic [3:0]        digits [TICK_DIGITS];
  logic [3:0]        digits_next [TICK_DIGITS];
  logic [BW-1:0]     bit_cnt;
  logic [DW-1:0]     dig_idx;
  logic              started;
  logic [PW-1:0]     raddr;
  logic [7:0]        rdata;
  logic [7:0]        ring [RING_DEPTH];
  logic              r_in_range;
  logic [14:0]       r_clen;
  logic              r_status;

  logic              we;
  logic [7:0]        wdata;
  logic [3:0]        cur_digit;
  logic              emit_digit;
  logic [PW-1:0]     head_next;
  logic [CW-1:0]     clen;
  logic [CW-1:0]     wm1;
  logic              idx_ok;
  logic [SW-1:0]     addr_sum;
  logic [SW-1:0]     addr_wrap;

  // Shift-and-add-3 step of the binary to decimal conversion
  always_comb begin
    logic [3:0] adj [TICK_DIGITS];
    for (int i = 0; i < TICK_DIGITS; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
    digits_next[0] = {adj[0][2:0], tick_sh[TICK_W-1]};
    for (int i = 1; i < TICK_DIGITS; i++) begin
      digits_next[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  assign cur_digit  = digits[dig_idx];
  assign emit_digit = started || (cur_digit != 4'd0) || (dig_idx == '0);

  always_comb begin
    we    = 1'b0;
    wdata = cur.char_byte;
    case (state)
      S_OPEN:  begin we = 1'b1; wdata = CH_LBRACK; end
      S_DIGIT: begin we = emit_digit; wdata = CH_ZERO + {4'd0, cur_digit}; end
      S_CLOSE: begin we = 1'b1; wdata = CH_RBRACK; end
      S_SPACE: begin we = 1'b1; wdata = CH_SPACE; end
      S_CHAR:  begin we = 1'b1; wdata = cur.char_byte; end
      default: begin we = 1'b0; end
    endcase
  end

  assign head_next = ({1'b0, head_ptr} + (PW+1)'(1) == (PW+1)'(RING_DEPTH)) ?
                     '0 : head_ptr + 1'b1;

  // Snapshot window: newest min(fill, window_size - 1) bytes
  always_comb begin
    wm1       = CW'(cur.window_size) - CW'(1);
    clen      = (CW'(fill_count) >= CW'(cur.window_size)) ? wm1 : CW'(fill_count);
    idx_ok    = CW'(cur.read_index) < clen;
    addr_sum  = SW'(head_ptr) + SW'(RING_DEPTH) - SW'(clen) + SW'(cur.read_index);
    addr_wrap = (addr_sum >= SW'(RING_DEPTH)) ? addr_sum - SW'(RING_DEPTH) : addr_sum;
  end

  assign cmd_ready       = (state == S_IDLE);
  assign res_valid       = (state == S_RD_OUT);
  assign res.data_byte   = r_in_range ? rdata : 8'd0;
  assign res.in_range    = r_in_range;
  assign res.copy_length = r_clen;
  assign res.status      = r_status;

  always_ff @(posedge clk) begin
    if (we) begin
      ring[head_ptr] <= wdata;
    end
    rdata <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head_ptr      <= '0;
      fill_count    <= '0;
      at_line_start <= 1'b1;
    end else begin
      if (we) begin
        head_ptr <= head_next;
        if (fill_count != FW'(RING_DEPTH)) fill_count <= fill_count + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            if (cmd.is_read) begin
              state <= S_RD_CALC;
            end else if (at_line_start) begin
              tick_sh <= cmd.tick_now;
              bit_cnt <= '0;
              for (int i = 0; i < TICK_DIGITS; i++) digits[i] <= 4'd0;
              state <= S_CONV;
            end else begin
              state <= S_CHAR;
            end
          end
        end
        S_CONV: begin
          digits  <= digits_next;
          tick_sh <= {tick_sh[TICK_W-2:0], 1'b0};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == BW'(TICK_W - 1)) state <= S_OPEN;
        end
        S_OPEN: begin
          dig_idx <= DW'(TICK_DIGITS - 1);
          started <= 1'b0;
          state   <= S_DIGIT;
        end
        S_DIGIT: begin
          if (emit_digit) started <= 1'b1;
          if (dig_idx == '0) begin
            state <= S_CLOSE;
          end else begin
            dig_idx <= dig_idx - 1'b1;
          end
        end
        S_CLOSE: state <= S_SPACE;
        S_SPACE: state <= S_CHAR;
        S_CHAR: begin
          at_line_start <= cur.is_eol;
          state         <= S_IDLE;
        end
        S_RD_CALC: begin
          if (cur.window_size == 15'd0) begin
            r_status   <= 1'b1;
            r_in_range <= 1'b0;
            r_clen     <= 15'd0;
            state      <= S_RD_OUT;
          end else begin
            r_status   <= 1'b0;
            r_in_range <= idx_ok;
            r_clen     <= 15'(clen);
            raddr      <= addr_wrap[PW-1:0];
            state      <= S_RD_MEM;
          end
        end
        S_RD_MEM: state <= S_RD_OUT;
        S_RD_OUT: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, clk, rst, fill_count <= FW'(RING_DEPTH), "fill count above depth")
  `ASSERT_ALWAYS(a_head_bound, clk, rst, {1'b0, head_ptr} < (PW+1)'(RING_DEPTH), "head out of ring")
  `ASSERT_ALWAYS(a_fill_step, clk, rst, (we && fill_count != FW'(RING_DEPTH)) |=> fill_count == $past(fill_count) + 1'b1, "fill count did not advance")
  `ASSERT_NEVER(a_err_range, clk, rst, res_valid && res.status && res.in_range, "error result marked in range")

endmodule

// ===== sv/ttr_result_q.sv =====
// Result queue toward the consumer
module ttr_result_q (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  output logic              res_ready,
  input  ttr_pkg::result_t  res,
  output logic              empty,
  input  logic              pop,
  output ttr_pkg::result_t  head
);
  import ttr_pkg::*;

  localparam int QPW = $clog2(RES_Q_DEPTH);

  result_t        q [RES_Q_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QPW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign res_ready = (count != (QPW+1)'(RES_Q_DEPTH));
  assign empty     = (count == '0);
  assign head      = q[rd_ptr];
  assign do_push   = res_valid && res_ready;
  assign do_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPW+1)'(do_push) - (QPW+1)'(do_pop);
    end
  end

endmodule

// ===== sv/timestamped_trace_ring_unit.sv =====
// Timestamped trace ring: top level
// Plain append: the back end steps through dispatch and ring write.
// Append at line start: dispatch, bit-serial decimal conversion of the 64-bit tick, open
// bracket, a slot for each of the 20 decimal digits, close bracket, space, byte.
// Read: dispatch, address, memory read, result; a zero window skips the memory read.
// The one back-end sequencer takes a new request only when idle; the front queue holds the rest.
// Synchronous reset clears pointers, fill count and queues and sets the line-start flag.
module timestamped_trace_ring_unit #(
  parameter int RING_DEPTH = ttr_pkg::DEFAULT_RING_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [7:0]  char_byte,
  input  logic [63:0] tick_now,
  input  logic [14:0] window_size,
  input  logic [13:0] read_index,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  data_byte,
  output logic        in_range,
  output logic [14:0] copy_length,
  output logic        status
);
  import ttr_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_ready;
  result_t res;
  logic    res_valid;
  logic    res_ready;
  result_t head;

  ttr_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .char_byte(char_byte), .tick_now(tick_now), .window_size(window_size),
    .read_index(read_index), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  ttr_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  ttr_result_q u_result_q (
    .clk(clk), .rst(rst), .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .empty(empty), .pop(pop), .head(head)
  );

  assign data_byte   = head.data_byte;
  assign in_range    = head.in_range;
  assign copy_length = head.copy_length;
  assign status      = head.status;

endmodule

// ===== verif/tb_timestamped_trace_ring_unit.sv =====
// Self-checking testbench for the timestamped trace ring unit
`timescale 1ns / 100ps

module tb_timestamped_trace_ring_unit;
  import ttr_pkg::*;

  localparam int DEPTH = DEFAULT_RING_DEPTH;
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_READ = 1'b1;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic        kind;
    logic [7:0]  ch;
    logic [63:0] tick;
    logic [14:0] wsize;
    logic [13:0] idx;
  } trace_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        kind = KIND_APPEND;
  logic [7:0]  char_byte = '0;
  logic [63:0] tick_now = '0;
  logic [14:0] window_size = '0;
  logic [13:0] read_index = '0;
  logic        pop = 1'b0;
  logic        full, empty, in_range, status;
  logic [7:0]  data_byte;
  logic [14:0] copy_length;

  trace_req_t req_q[$];
  result_t    snap_q[$];
  trace_req_t cur_req;
  int         errors = 0;
  int         cycle = 0;
  int         burst_left = 0;
  int         gap_left = 0;

  // golden copy of the ring state
  logic [7:0]  ring_mem[DEPTH];
  int          ring_head = 0;
  int          ring_fill = 0;
  logic        line_start = 1'b1;

  timestamped_trace_ring_unit uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .char_byte(char_byte), .tick_now(tick_now), .window_size(window_size),
    .read_index(read_index), .empty(empty), .pop(pop), .data_byte(data_byte),
    .in_range(in_range), .copy_length(copy_length), .status(status)
  );

  always #5 clk = ~clk;

  task automatic ring_write(input logic [7:0] b);
    ring_mem[ring_head] = b;
    ring_head = (ring_head + 1) % DEPTH;
    if (ring_fill < DEPTH) ring_fill++;
  endtask

  task automatic log_byte(input logic [7:0] ch, input logic [63:0] tick);
    logic [7:0]  digs[20];
    logic [63:0] t;
    int          n;
    if (line_start) begin
      t = tick;
      n = 0;
      do begin
        digs[n] = CH_ZERO + 8'(t % 10);
        n++;
        t = t / 10;
      end while (t != 0 && n < 20);
      ring_write(CH_LBRACK);
      while (n > 0) begin
        n--;
        ring_write(digs[n]);
      end
      ring_write(CH_RBRACK);
      ring_write(CH_SPACE);
      line_start = 1'b0;
    end
    ring_write(ch);
    if (ch == CH_LF || ch == CH_CR) line_start = 1'b1;
  endtask

  task automatic snapshot_byte(input logic [14:0] wsize, input logic [13:0] idx);
    result_t r;
    int      clen;
    r = '0;
    if (wsize == 0) begin
      r.status = 1'b1;
    end else begin
      clen = (ring_fill >= wsize) ? wsize - 1 : ring_fill;
      if (idx < clen) begin
        r.data_byte = ring_mem[(ring_head + DEPTH - clen + idx) % DEPTH];
        r.in_range = 1'b1;
      end
      r.copy_length = 15'(clen);
    end
    snap_q.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", field, got, want, cycle);
    errors++;
  endtask

  function automatic trace_req_t make_req(input logic k, input logic [7:0] ch,
                                          input logic [63:0] tick, input logic [14:0] ws,
                                          input logic [13:0] ix);
    trace_req_t r;
    r.kind = k;
    r.ch = ch;
    r.tick = tick;
    r.wsize = ws;
    r.idx = ix;
    return r;
  endfunction

  function automatic logic [63:0] rand_tick();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  // driver: hold while full, otherwise pick next request or idle
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        if (cur_req.kind == KIND_APPEND) log_byte(cur_req.ch, cur_req.tick);
        else snapshot_byte(cur_req.wsize, cur_req.idx);
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          kind <= cur_req.kind;
          char_byte <= cur_req.ch;
          tick_now <= cur_req.tick;
          window_size <= cur_req.wsize;
          read_index <= cur_req.idx;
          push <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    result_t want;
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle);
      $display("Some tests failed");
      $finish;
    end
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (snap_q.size() == 0) begin
          $display("Unexpected result at cycle %0d", cycle);
          errors++;
        end else begin
          want = snap_q.pop_front();
          if (data_byte !== want.data_byte)
            report_mismatch("data_byte", data_byte, want.data_byte);
          if (in_range !== want.in_range)
            report_mismatch("in_range", in_range, want.in_range);
          if (copy_length !== want.copy_length)
            report_mismatch("copy_length", copy_length, want.copy_length);
          if (status !== want.status)
            report_mismatch("status", status, want.status);
        end
      end
      case (cycle[12:11])
        2'd0: pop <= 1'b1;
        2'd1: pop <= ($urandom_range(0, 3) != 0);
        2'd2: pop <= (cycle[3:0] < 4);
        default: pop <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  initial begin
    int ws;
    // empty ring: zero, minimal and oversize windows
    req_q.push_back(make_req(KIND_READ, 8'h00, '0, 15'd0, 14'd0));
    req_q.push_back(make_req(KIND_READ, 8'h00, '0, 15'd1, 14'd0));
    req_q.push_back(make_req(KIND_READ, 8'h00, '0, 15'd16385, 14'd16383));
    // tick of zero, maximum tick after a newline, then tick 10 after a carriage return
    req_q.push_back(make_req(KIND_APPEND, 8'h41, 64'd0, '0, '0));
    req_q.push_back(make_req(KIND_APPEND, CH_LF, 64'd7, '0, '0));
    req_q.push_back(make_req(KIND_APPEND, 8'hFF, '1, '0, '0));
    req_q.push_back(make_req(KIND_APPEND, CH_CR, 64'd3, '0, '0));
    req_q.push_back(make_req(KIND_APPEND, 8'h00, 64'd10, '0, '0));
    for (int i = 0; i < 10; i++)
      req_q.push_back(make_req(KIND_READ, '0, '0, 15'd16385, 14'(i)));
    req_q.push_back(make_req(KIND_READ, '0, '0, 15'd5, 14'd4));
    req_q.push_back(make_req(KIND_READ, '0, '0, 15'd0, 14'd3));
    // newlines and carriage returns, every third with a maximal tick prefix
    for (int i = 0; i < 720; i++)
      req_q.push_back(make_req(KIND_APPEND, ($urandom_range(0, 1) ? CH_LF : CH_CR),
                               (i % 3 == 0) ? '1 : rand_tick(), '0, '0));
    req_q.push_back(make_req(KIND_READ, '0, '0, 15'd16385, 14'd16383));
    req_q.push_back(make_req(KIND_READ, '0, '0, 15'd16384, 14'd16383));
    req_q.push_back(make_req(KIND_READ, '0, '0, 15'd16385, 14'd0));
    for (int i = 0; i < 780; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        req_q.push_back(make_req(KIND_APPEND,
                                 ($urandom_range(0, 9) == 0) ? CH_LF : 8'($urandom),
                                 rand_tick(), 15'($urandom), 14'($urandom)));
      end else begin
        case ($urandom_range(0, 3))
          0: ws = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          1: ws = $urandom_range(16380, 16385);
          default: ws = $urandom_range(0, 16385);
        endcase
        req_q.push_back(make_req(KIND_READ, 8'($urandom), rand_tick(), 15'(ws),
                                 ($urandom_range(0, 4) == 0) ? 14'($urandom)
                                   : 14'($urandom_range(0, (ws > 0) ? ws - 1 : 0))));
      end
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (req_q.size() == 0 && !push && snap_q.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && snap_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ttr_pkg.sv
sv/ttr_front.sv
sv/ttr_back.sv
sv/ttr_result_q.sv
sv/timestamped_trace_ring_unit.sv
verif/tb_timestamped_trace_ring_unit.sv
